### hw/rtl/lst_pkg.sv
// Shared types and constants for the lazy segment tree controller and datapath.
package lst_pkg;

  // Command codes of an input beat.
  localparam logic [1:0] CMD_POINT_ADD = 2'd0;
  localparam logic [1:0] CMD_RANGE_ADD = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;

  // Reset value of the leaves_in_use register.
  localparam logic [10:0] LEAVES_RESET = 11'd1024;

  // Walk phase of a stack frame.
  typedef enum logic [1:0] {
    PH_NEW   = 2'd0,
    PH_LEFT  = 2'd1,
    PH_RIGHT = 2'd2
  } phase_t;

  // Micro-operations the controller issues to the datapath.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_CA_RD,
    OP_CA_M1,
    OP_MUL_HI,
    OP_CA_WR,
    OP_Q_RD,
    OP_Q_ACC,
    OP_PD_RD,
    OP_PD_T,
    OP_PD_L1,
    OP_PD_LW,
    OP_PD_R1,
    OP_PD_RW,
    OP_PD_CLR,
    OP_DESC_L,
    OP_DESC_R,
    OP_POP,
    OP_CB_R1,
    OP_CB_R2,
    OP_CB_WR,
    OP_EMIT
  } dp_op_t;

  // Status the datapath reports to the controller.
  typedef struct packed {
    logic   item_go;
    logic   item_query;
    logic   disjoint;
    logic   covered;
    logic   is_query;
    logic   tag_zero;
    logic   sp_zero;
    phase_t top_phase;
    logic   out_free;
    logic   clear_last;
  } dp_status_t;

endpackage

### hw/rtl/lst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/lst_ctrl.sv
// Controller state machine that sequences the tree walk one node step at a time.
module lst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lst_pkg::dp_status_t status,
  output lst_pkg::dp_op_t     op
);

  typedef enum logic [24:0] {
    ST_CLEAR  = 25'h0000001,
    ST_IDLE   = 25'h0000002,
    ST_VISIT  = 25'h0000004,
    ST_CA_RD  = 25'h0000008,
    ST_CA_M1  = 25'h0000010,
    ST_CA_M2  = 25'h0000020,
    ST_CA_WR  = 25'h0000040,
    ST_Q_RD   = 25'h0000080,
    ST_Q_ACC  = 25'h0000100,
    ST_PD_RD  = 25'h0000200,
    ST_PD_T   = 25'h0000400,
    ST_PD_L1  = 25'h0000800,
    ST_PD_L2  = 25'h0001000,
    ST_PD_LW  = 25'h0002000,
    ST_PD_R1  = 25'h0004000,
    ST_PD_R2  = 25'h0008000,
    ST_PD_RW  = 25'h0010000,
    ST_PD_CLR = 25'h0020000,
    ST_DESC_L = 25'h0040000,
    ST_RET    = 25'h0080000,
    ST_RESUME = 25'h0100000,
    ST_CB_R1  = 25'h0200000,
    ST_CB_R2  = 25'h0400000,
    ST_CB_WR  = 25'h0800000,
    ST_FINISH = 25'h1000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and micro-operation decode.
  always_comb begin
    state_next = state;
    op         = lst_pkg::OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        op = lst_pkg::OP_CLEAR;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = lst_pkg::OP_LOAD;
          if (status.item_go) begin
            state_next = ST_VISIT;
          end else if (status.item_query) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_VISIT: begin
        if (status.disjoint) begin
          state_next = ST_RET;
        end else if (status.covered) begin
          state_next = status.is_query ? ST_Q_RD : ST_CA_RD;
        end else begin
          state_next = ST_PD_RD;
        end
      end
      ST_CA_RD: begin
        op         = lst_pkg::OP_CA_RD;
        state_next = ST_CA_M1;
      end
      ST_CA_M1: begin
        op         = lst_pkg::OP_CA_M1;
        state_next = ST_CA_M2;
      end
      ST_CA_M2: begin
        op         = lst_pkg::OP_MUL_HI;
        state_next = ST_CA_WR;
      end
      ST_CA_WR: begin
        op         = lst_pkg::OP_CA_WR;
        state_next = ST_RET;
      end
      ST_Q_RD: begin
        op         = lst_pkg::OP_Q_RD;
        state_next = ST_Q_ACC;
      end
      ST_Q_ACC: begin
        op         = lst_pkg::OP_Q_ACC;
        state_next = ST_RET;
      end
      ST_PD_RD: begin
        op         = lst_pkg::OP_PD_RD;
        state_next = ST_PD_T;
      end
      ST_PD_T: begin
        op         = lst_pkg::OP_PD_T;
        state_next = status.tag_zero ? ST_DESC_L : ST_PD_L1;
      end
      ST_PD_L1: begin
        op         = lst_pkg::OP_PD_L1;
        state_next = ST_PD_L2;
      end
      ST_PD_L2: begin
        op         = lst_pkg::OP_MUL_HI;
        state_next = ST_PD_LW;
      end
      ST_PD_LW: begin
        op         = lst_pkg::OP_PD_LW;
        state_next = ST_PD_R1;
      end
      ST_PD_R1: begin
        op         = lst_pkg::OP_PD_R1;
        state_next = ST_PD_R2;
      end
      ST_PD_R2: begin
        op         = lst_pkg::OP_MUL_HI;
        state_next = ST_PD_RW;
      end
      ST_PD_RW: begin
        op         = lst_pkg::OP_PD_RW;
        state_next = ST_PD_CLR;
      end
      ST_PD_CLR: begin
        op         = lst_pkg::OP_PD_CLR;
        state_next = ST_DESC_L;
      end
      ST_DESC_L: begin
        op         = lst_pkg::OP_DESC_L;
        state_next = ST_VISIT;
      end
      ST_RET: begin
        if (status.sp_zero) begin
          state_next = ST_FINISH;
        end else begin
          op         = lst_pkg::OP_POP;
          state_next = ST_RESUME;
        end
      end
      ST_RESUME: begin
        // A parent whose left child is done moves on to the right child;
        // after both, an add rebuilds the parent sum from its children.
        if (status.top_phase == lst_pkg::PH_LEFT) begin
          op         = lst_pkg::OP_DESC_R;
          state_next = ST_VISIT;
        end else if (status.is_query) begin
          state_next = ST_RET;
        end else begin
          state_next = ST_CB_R1;
        end
      end
      ST_CB_R1: begin
        op         = lst_pkg::OP_CB_R1;
        state_next = ST_CB_R2;
      end
      ST_CB_R2: begin
        op         = lst_pkg::OP_CB_R2;
        state_next = ST_CB_WR;
      end
      ST_CB_WR: begin
        op         = lst_pkg::OP_CB_WR;
        state_next = ST_RET;
      end
      ST_FINISH: begin
        if (!status.is_query) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          op         = lst_pkg::OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/lst_datapath.sv
// Datapath: item registers, walk stack, node and tag stores, multiply and output register.
module lst_datapath #(
  parameter int LEAVES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [10:0]         cfg_wdata,
  input  logic [1:0]          cmd,
  input  logic [9:0]          lo_index,
  input  logic [9:0]          hi_index,
  input  logic signed [31:0]  add_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  range_sum,
  input  lst_pkg::dp_op_t     op,
  output lst_pkg::dp_status_t status
);

  localparam int STORE_DEPTH = 4 * LEAVES;
  localparam int NODE_W      = $clog2(STORE_DEPTH);
  localparam int P_W         = ($clog2(LEAVES + 1) > 11) ? $clog2(LEAVES + 1) : 11;
  localparam int PL_W        = P_W + 32;
  localparam int SD          = $clog2(LEAVES) + 1;
  localparam int SP_W        = (SD > 1) ? $clog2(SD) : 1;

  // Configuration and item registers.
  logic [10:0]       leaves_q;
  logic [1:0]        cmd_q;
  logic [P_W-1:0]    l_q;
  logic [P_W-1:0]    r_q;
  logic [63:0]       v_q;
  logic [63:0]       acc;
  logic [63:0]       t_q;
  logic [63:0]       cap_sum;
  logic [63:0]       cap_lazy;
  logic [P_W-1:0]    m_cnt;
  logic [63:0]       m_val;
  logic [PL_W-1:0]   p_lo;
  logic [63:0]       prod;
  logic [NODE_W-1:0] clr_addr;
  logic [SP_W-1:0]   sp;
  logic [63:0]       range_sum_q;

  // Walk stack frames.
  logic [NODE_W-1:0]   stk_n  [SD];
  logic [P_W-1:0]      stk_s  [SD];
  logic [P_W-1:0]      stk_e  [SD];
  lst_pkg::phase_t     stk_ph [SD];

  // RAM ports.
  logic              s_we, z_we;
  logic [NODE_W-1:0] s_waddr, z_waddr, s_raddr, z_raddr;
  logic [63:0]       s_wdata, z_wdata, s_rdata, z_rdata;

  // Derived values.
  logic [P_W-1:0]    leaves_ext, e_eff, last, lo_ext, hi_ext;
  logic [NODE_W-1:0] top_n, node_l, node_r;
  logic [P_W-1:0]    top_s, top_e, mid;
  logic [P_W:0]      sum_se;
  logic [SP_W-1:0]   sp_inc;
  logic [P_W-1:0]    cnt_sel;
  logic [63:0]       val_sel;
  logic [PL_W-1:0]   mul_lo, mul_hi;

  // Effective tree span from the register, clipped to 1 .. LEAVES.
  assign leaves_ext = P_W'(leaves_q);
  always_comb begin
    if (leaves_q == 11'd0) begin
      e_eff = P_W'(1);
    end else if (leaves_ext > P_W'(LEAVES)) begin
      e_eff = P_W'(LEAVES);
    end else begin
      e_eff = leaves_ext;
    end
  end
  assign last   = e_eff - P_W'(1);
  assign lo_ext = P_W'(lo_index);
  assign hi_ext = P_W'(hi_index);

  // Current frame and its children.
  assign top_n  = stk_n[sp];
  assign top_s  = stk_s[sp];
  assign top_e  = stk_e[sp];
  assign sum_se = {1'b0, top_s} + {1'b0, top_e};
  assign mid    = sum_se[P_W:1];
  assign node_l = {top_n[NODE_W-2:0], 1'b0};
  assign node_r = {top_n[NODE_W-2:0], 1'b1};
  assign sp_inc = sp + SP_W'(1);

  // Status toward the controller.
  always_comb begin
    status.item_go    = ((cmd == lst_pkg::CMD_POINT_ADD) && (lo_ext <= last)) ||
                        ((cmd == lst_pkg::CMD_RANGE_ADD) && (lo_index <= hi_index)) ||
                        ((cmd == lst_pkg::CMD_QUERY) && (lo_index <= hi_index));
    status.item_query = (cmd == lst_pkg::CMD_QUERY);
    status.disjoint   = (top_s > r_q) || (top_e < l_q);
    status.covered    = (l_q <= top_s) && (top_e <= r_q);
    status.is_query   = (cmd_q == lst_pkg::CMD_QUERY);
    status.tag_zero   = (z_rdata == 64'd0);
    status.sp_zero    = (sp == SP_W'(0));
    status.top_phase  = stk_ph[sp];
    status.out_free   = !out_valid || out_ready;
    status.clear_last = (clr_addr == NODE_W'(STORE_DEPTH - 1));
  end

  // Multiply operands: segment length times the added value or pushed tag.
  always_comb begin
    case (op)
      lst_pkg::OP_PD_L1: begin
        cnt_sel = mid - top_s + P_W'(1);
        val_sel = t_q;
      end
      lst_pkg::OP_PD_R1: begin
        cnt_sel = top_e - mid;
        val_sel = t_q;
      end
      default: begin
        cnt_sel = top_e - top_s + P_W'(1);
        val_sel = v_q;
      end
    endcase
  end
  assign mul_lo = PL_W'(cnt_sel) * PL_W'(val_sel[31:0]);
  assign mul_hi = PL_W'(m_cnt) * PL_W'(m_val[63:32]);

  // Store addressing and write data.
  always_comb begin
    s_we    = 1'b0;
    z_we    = 1'b0;
    s_waddr = top_n;
    z_waddr = top_n;
    s_wdata = 64'd0;
    z_wdata = 64'd0;
    s_raddr = top_n;
    z_raddr = top_n;
    case (op)
      lst_pkg::OP_CLEAR: begin
        s_we    = 1'b1;
        z_we    = 1'b1;
        s_waddr = clr_addr;
        z_waddr = clr_addr;
      end
      lst_pkg::OP_CA_WR: begin
        s_we    = 1'b1;
        z_we    = 1'b1;
        s_wdata = cap_sum + prod;
        z_wdata = cap_lazy + v_q;
      end
      lst_pkg::OP_PD_T: begin
        s_raddr = node_l;
        z_raddr = node_l;
      end
      lst_pkg::OP_PD_LW: begin
        s_we    = 1'b1;
        z_we    = 1'b1;
        s_waddr = node_l;
        z_waddr = node_l;
        s_wdata = cap_sum + prod;
        z_wdata = cap_lazy + t_q;
        s_raddr = node_r;
        z_raddr = node_r;
      end
      lst_pkg::OP_PD_RW: begin
        s_we    = 1'b1;
        z_we    = 1'b1;
        s_waddr = node_r;
        z_waddr = node_r;
        s_wdata = cap_sum + prod;
        z_wdata = cap_lazy + t_q;
      end
      lst_pkg::OP_PD_CLR: begin
        z_we = 1'b1;
      end
      lst_pkg::OP_CB_R1: begin
        s_raddr = node_l;
      end
      lst_pkg::OP_CB_R2: begin
        s_raddr = node_r;
      end
      lst_pkg::OP_CB_WR: begin
        s_we    = 1'b1;
        s_wdata = cap_sum + s_rdata;
      end
      default: begin
        s_we = 1'b0;
      end
    endcase
  end

  // Control registers: configuration, stack pointer, clear sweep, output beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      leaves_q  <= lst_pkg::LEAVES_RESET;
      sp        <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        leaves_q <= cfg_wdata;
      end
      if (op == lst_pkg::OP_CLEAR) begin
        clr_addr <= clr_addr + NODE_W'(1);
      end
      case (op)
        lst_pkg::OP_LOAD:   sp <= '0;
        lst_pkg::OP_DESC_L: sp <= sp_inc;
        lst_pkg::OP_DESC_R: sp <= sp_inc;
        lst_pkg::OP_POP:    sp <= sp - SP_W'(1);
        default:            sp <= sp;
      endcase
      if (op == lst_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (op) inside
      lst_pkg::OP_LOAD: begin
        cmd_q <= cmd;
        l_q   <= lo_ext;
        r_q   <= (cmd == lst_pkg::CMD_POINT_ADD) ? lo_ext : hi_ext;
        v_q   <= {{32{add_value[31]}}, add_value};
        acc   <= 64'd0;
      end
      lst_pkg::OP_CA_M1, lst_pkg::OP_PD_L1, lst_pkg::OP_PD_R1: begin
        cap_sum  <= s_rdata;
        cap_lazy <= z_rdata;
        m_cnt    <= cnt_sel;
        m_val    <= val_sel;
        p_lo     <= mul_lo;
      end
      lst_pkg::OP_MUL_HI: begin
        prod <= {{(64 - PL_W){1'b0}}, p_lo} + {mul_hi[31:0], 32'd0};
      end
      lst_pkg::OP_Q_ACC: begin
        acc <= acc + s_rdata;
      end
      lst_pkg::OP_PD_T: begin
        t_q <= z_rdata;
      end
      lst_pkg::OP_CB_R2: begin
        cap_sum <= s_rdata;
      end
      lst_pkg::OP_EMIT: begin
        range_sum_q <= acc;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // Stack frame writes: root on load, a child on each descent.
  always_ff @(posedge clk) begin
    case (op)
      lst_pkg::OP_LOAD: begin
        stk_n[0]  <= NODE_W'(1);
        stk_s[0]  <= '0;
        stk_e[0]  <= last;
        stk_ph[0] <= lst_pkg::PH_NEW;
      end
      lst_pkg::OP_DESC_L: begin
        stk_ph[sp]     <= lst_pkg::PH_LEFT;
        stk_n[sp_inc]  <= node_l;
        stk_s[sp_inc]  <= top_s;
        stk_e[sp_inc]  <= mid;
        stk_ph[sp_inc] <= lst_pkg::PH_NEW;
      end
      lst_pkg::OP_DESC_R: begin
        stk_ph[sp]     <= lst_pkg::PH_RIGHT;
        stk_n[sp_inc]  <= node_r;
        stk_s[sp_inc]  <= mid + P_W'(1);
        stk_e[sp_inc]  <= top_e;
        stk_ph[sp_inc] <= lst_pkg::PH_NEW;
      end
      default: begin
        stk_ph[sp] <= stk_ph[sp];
      end
    endcase
  end

  assign range_sum = range_sum_q;

  // Node sum store.
  lst_ram #(
    .WIDTH (64),
    .DEPTH (STORE_DEPTH)
  ) u_sum_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Pending tag store.
  lst_ram #(
    .WIDTH (64),
    .DEPTH (STORE_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (z_we),
    .waddr (z_waddr),
    .wdata (z_wdata),
    .raddr (z_raddr),
    .rdata (z_rdata)
  );

endmodule

### hw/rtl/lazy_segment_tree_range_add_sum.sv
// Top level of the lazy segment tree with range add and range sum.
// Input channel (in_valid/in_ready): one beat carries cmd, lo_index, hi_index
// and add_value. Point add and range add give no result; a range sum query
// gives one beat on the output channel (out_valid/out_ready, range_sum).
// The register leaves_in_use is written through cfg_wen/cfg_wdata; the user must
// write it only while idle, as the block does not enforce this. One item is worked
// at a time. The walk visits each touched node through a stack; a covered add
// reads the node, multiplies and writes it back, a covered query node reads and
// accumulates, a push-down reads the tag and, if it is not zero, pushes it into
// both children and clears it, and a rebuild reads both children and writes the
// parent sum. A typical operation on a tree of 1024 leaves touches about two
// root-to-leaf paths; the walk is bound by the single read port of each store.
// After reset both stores are cleared, all 4*LEAVES entries, one entry a cycle,
// before in_ready rises. A finished sum waits in the output register; the next
// item is accepted meanwhile, and a second sum waits until the first beat is
// taken.
module lazy_segment_tree_range_add_sum #(
  parameter int LEAVES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [10:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [9:0]         lo_index,
  input  logic [9:0]         hi_index,
  input  logic signed [31:0] add_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] range_sum
);

  lst_pkg::dp_op_t     op;
  lst_pkg::dp_status_t status;

  // Sequencer.
  lst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  // Stores, stack and arithmetic.
  lst_datapath #(
    .LEAVES (LEAVES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .lo_index  (lo_index),
    .hi_index  (hi_index),
    .add_value (add_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .range_sum (range_sum),
    .op        (op),
    .status    (status)
  );

endmodule

### verif/lst_checker.sv
// Checker for the lazy segment tree: tracks the tree contents and compares query sums.
module lst_checker #(
  parameter int LEAVES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [10:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [9:0]         lo_index,
  input  logic [9:0]         hi_index,
  input  logic signed [31:0] add_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [63:0] range_sum,
  output int                 fail_count,
  output int                 pending_sums
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 4 * LEAVES;

  // Shadow copy of the node sums, the pending tags and the register.
  logic [63:0] node_total [DEPTH];
  logic [63:0] node_tag [DEPTH];
  logic [10:0] leaves_reg;
  logic [63:0] sum_queue [$];

  // Last covered position for the current register value.
  function automatic int unsigned last_leaf();
    int unsigned e;
    e = 32'(leaves_reg);
    if (e == 0) e = 1;
    if (e > LEAVES) e = LEAVES;
    return e - 1;
  endfunction

  // Move a node's pending tag into its two children.
  function automatic void spread_tag(int unsigned n, int unsigned s, int unsigned m,
                                     int unsigned e);
    logic [63:0] t;
    logic [63:0] left_cnt;
    logic [63:0] right_cnt;
    t = node_tag[n];
    left_cnt = 64'(m - s + 1);
    right_cnt = 64'(e - m);
    if (t == 64'd0) return;
    node_tag[2*n]       = node_tag[2*n] + t;
    node_tag[2*n+1]     = node_tag[2*n+1] + t;
    node_total[2*n]     = node_total[2*n] + left_cnt * t;
    node_total[2*n+1]   = node_total[2*n+1] + right_cnt * t;
    node_tag[n]         = 64'd0;
  endfunction

  // Add a value to every position of l..r under node n spanning s..e.
  function automatic void add_span(int unsigned n, int unsigned s, int unsigned e,
                                   int unsigned l, int unsigned r, logic [63:0] v);
    int unsigned m;
    logic [63:0] cnt;
    cnt = 64'(e - s + 1);
    if (s > r || e < l) return;
    if (l <= s && e <= r) begin
      node_total[n] = node_total[n] + cnt * v;
      node_tag[n]   = node_tag[n] + v;
      return;
    end
    m = (s + e) / 2;
    spread_tag(n, s, m, e);
    add_span(2*n, s, m, l, r, v);
    add_span(2*n+1, m + 1, e, l, r, v);
    node_total[n] = node_total[2*n] + node_total[2*n+1];
  endfunction

  // Sum of positions l..r under node n spanning s..e, modulo 2^64.
  function automatic logic [63:0] sum_span(int unsigned n, int unsigned s, int unsigned e,
                                           int unsigned l, int unsigned r);
    int unsigned m;
    if (s > r || e < l) return 64'd0;
    if (l <= s && e <= r) return node_total[n];
    m = (s + e) / 2;
    spread_tag(n, s, m, e);
    return sum_span(2*n, s, m, l, r) + sum_span(2*n+1, m + 1, e, l, r);
  endfunction

  // Watch both channels and the register port on every edge.
  always @(posedge clk) begin
    logic [63:0] v;
    logic [63:0] want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        node_total[i] = 64'd0;
        node_tag[i]   = 64'd0;
      end
      leaves_reg = lst_pkg::LEAVES_RESET;
      sum_queue.delete();
      fail_count = 0;
      pending_sums = 0;
    end else begin
      if (cfg_wen) leaves_reg = cfg_wdata;
      // Input beat: update the shadow tree, queue a sum for a query.
      if (in_valid && in_ready) begin
        v = {{32{add_value[31]}}, add_value};
        case (cmd)
          lst_pkg::CMD_POINT_ADD: begin
            if (32'(lo_index) <= last_leaf())
              add_span(1, 0, last_leaf(), 32'(lo_index), 32'(lo_index), v);
          end
          lst_pkg::CMD_RANGE_ADD: begin
            if (lo_index <= hi_index)
              add_span(1, 0, last_leaf(), 32'(lo_index), 32'(hi_index), v);
          end
          lst_pkg::CMD_QUERY: begin
            if (lo_index <= hi_index)
              want = sum_span(1, 0, last_leaf(), 32'(lo_index), 32'(hi_index));
            else
              want = 64'd0;
            sum_queue = {sum_queue, want};
          end
          default: ;
        endcase
      end
      // Output beat: compare with the oldest queued sum.
      if (out_valid && out_ready) begin
        if (sum_queue.size() == 0) begin
          $display("%0t: unexpected range_sum beat, expected none, actual %0d", $time,
                   range_sum);
          fail_count++;
        end else begin
          want = sum_queue.pop_front();
          if (range_sum !== want) begin
            $display("%0t: range_sum mismatch, expected %0d actual %0d", $time,
                     $signed(want), range_sum);
            fail_count++;
          end
        end
      end
      pending_sums = sum_queue.size();
    end
  end

endmodule

### verif/testbench.sv
// Top of the lazy segment tree testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEAVES = 1024;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 3000;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 120;

  logic               clk;
  logic               rst;
  logic               cfg_wen;
  logic [10:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         cmd;
  logic [9:0]         lo_index;
  logic [9:0]         hi_index;
  logic signed [31:0] add_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] range_sum;
  int                 fail_count;
  int                 pending_sums;

  int send_idle_pct;
  int recv_idle_pct;
  int span_leaves;
  int cycle_count = 0;

  lazy_segment_tree_range_add_sum #(.LEAVES(LEAVES)) u_top (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .lo_index(lo_index),
    .hi_index(hi_index), .add_value(add_value), .out_valid(out_valid),
    .out_ready(out_ready), .range_sum(range_sum)
  );

  lst_checker #(.LEAVES(LEAVES)) u_checker (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .lo_index(lo_index),
    .hi_index(hi_index), .add_value(add_value), .out_valid(out_valid),
    .out_ready(out_ready), .range_sum(range_sum), .fail_count(fail_count),
    .pending_sums(pending_sums)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random according to the current idle rate.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** lazy_segment_tree_range_add_sum: FAILED **");
      $finish;
    end
  end

  // Present one beat and hold it until it is accepted.
  task automatic send_beat(logic [1:0] c, logic [9:0] lo, logic [9:0] hi,
                           logic [31:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    lo_index  <= lo;
    hi_index  <= hi;
    add_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let every queued sum arrive, then let a trailing add finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sums != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the register while the block is idle.
  task automatic write_leaves(logic [10:0] val);
    cfg_wen   <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    span_leaves = (val == 0) ? 1 : (val > LEAVES) ? LEAVES : val;
  endtask

  // One random command, mostly well-formed ranges inside the covered span.
  task automatic send_random();
    int pick;
    int a;
    int b;
    logic [1:0] c;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    c = (pick < 30) ? lst_pkg::CMD_POINT_ADD : (pick < 60) ? lst_pkg::CMD_RANGE_ADD :
        (pick < 96) ? lst_pkg::CMD_QUERY : CMD_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      a = $urandom_range(0, span_leaves - 1);
      b = $urandom_range(0, span_leaves - 1);
      if (a > b) begin
        pick = a; a = b; b = pick;
      end
    end else if (pick < 85) begin
      a = $urandom_range(0, 1023);
      b = $urandom_range(0, 1023);
    end else begin
      a = $urandom_range(0, 3);
      b = span_leaves - 1 + $urandom_range(0, 2);
      if (b > 1023) b = 1023;
    end
    v = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 200) - 100;
    send_beat(c, a[9:0], b[9:0], v);
  endtask

  initial begin
    logic [10:0] phase_leaves [NUM_PHASES];
    phase_leaves = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd37, 11'd1000, 11'd513,
                     11'd1024};
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    cmd = lst_pkg::CMD_POINT_ADD;
    lo_index = '0;
    hi_index = '0;
    add_value = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    span_leaves = LEAVES;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed checks at the full tree size: extreme values and ranges.
    send_beat(lst_pkg::CMD_POINT_ADD, 10'd0, 10'd0, 32'h7FFF_FFFF);
    send_beat(lst_pkg::CMD_POINT_ADD, 10'd1023, 10'd5, 32'h8000_0000);
    send_beat(lst_pkg::CMD_QUERY, 10'd0, 10'd1023, '0);
    send_beat(lst_pkg::CMD_RANGE_ADD, 10'd0, 10'd1023, 32'hFFFF_FFFF);
    send_beat(lst_pkg::CMD_QUERY, 10'd0, 10'd0, '0);
    send_beat(lst_pkg::CMD_QUERY, 10'd1023, 10'd1023, '0);
    send_beat(lst_pkg::CMD_RANGE_ADD, 10'd700, 10'd300, 32'd55);
    send_beat(lst_pkg::CMD_QUERY, 10'd600, 10'd400, '0);
    send_beat(CMD_UNUSED, 10'd3, 10'd9, 32'd1234);
    send_beat(lst_pkg::CMD_RANGE_ADD, 10'd511, 10'd512, 32'h7FFF_FFFF);
    send_beat(lst_pkg::CMD_RANGE_ADD, 10'd1, 10'd1022, 32'h8000_0000);
    send_beat(lst_pkg::CMD_QUERY, 10'd510, 10'd513, '0);
    send_beat(lst_pkg::CMD_QUERY, 10'd0, 10'd1023, '0);
    drain();

    // Directed checks at a single leaf, with a clipped range and a far point.
    write_leaves(11'd1);
    send_beat(lst_pkg::CMD_POINT_ADD, 10'd5, 10'd5, 32'd77);
    send_beat(lst_pkg::CMD_RANGE_ADD, 10'd0, 10'd1023, 32'd9);
    send_beat(lst_pkg::CMD_QUERY, 10'd0, 10'd1023, '0);
    send_beat(lst_pkg::CMD_QUERY, 10'd1, 10'd1023, '0);
    drain();
    write_leaves(11'd1024);

    // Random phases over several tree sizes and idle patterns.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 37; recv_idle_pct = 76;
      end else if (p < 6) begin
        send_idle_pct = 76; recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      write_leaves(phase_leaves[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Once mid-phase the sender holds off until every sum has come back.
        if (p == 4 && i == ITEMS_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_sums != 0) @(posedge clk);
        end
        send_random();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("** lazy_segment_tree_range_add_sum: PASSED **");
    end else begin
      $display("** lazy_segment_tree_range_add_sum: FAILED **");
    end
    $finish;
  end
endmodule

### filelist.f
hw/rtl/lst_pkg.sv
hw/rtl/lst_ram.sv
hw/rtl/lst_ctrl.sv
hw/rtl/lst_datapath.sv
hw/rtl/lazy_segment_tree_range_add_sum.sv
verif/lst_checker.sv
verif/testbench.sv
